// File: src/pkae_pkg.sv
// shared types and constants for the point kinematics and error unit
// no dependencies; used by pkae_cross and point_kinematics_and_error_unit
`timescale 1ns / 1ps
`default_nettype none

package pkae_pkg;

   // default component width (vector q7.x, rotation q1.x)
   localparam int COMPONENT_BITS = 20;

   // width of one packed field on the ports
   localparam int FIELD_BITS = 60;

   // register index port width and register codes
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LOCAL_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOCAL_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOCAL_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_X  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_Y  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_Z  = 3'd5;

   // input word: pose and motion sample
   typedef struct packed {
      logic [FIELD_BITS-1:0] rot_row0;
      logic [FIELD_BITS-1:0] rot_row1;
      logic [FIELD_BITS-1:0] rot_row2;
      logic [FIELD_BITS-1:0] joint_origin;
      logic [FIELD_BITS-1:0] lin_vel;
      logic [FIELD_BITS-1:0] ang_vel;
      logic [FIELD_BITS-1:0] lin_acc;
      logic [FIELD_BITS-1:0] ang_acc;
   } req_word_type;

   // result word: point position, velocity, acceleration and error
   typedef struct packed {
      logic [FIELD_BITS-1:0] point_pos;
      logic [FIELD_BITS-1:0] point_vel;
      logic [FIELD_BITS-1:0] point_acc;
      logic [FIELD_BITS-1:0] pos_error;
   } rsp_word_type;

   // load enables for the two register stages of a cross product unit
   typedef struct packed {
      logic prod;
      logic diff;
   } cross_en_type;

endpackage

`default_nettype wire

// File: src/pkae_cross.sv
// two-stage pipelined cross product a x b with round-to-nearest rescale
// depends on pkae_pkg (cross_en_type)
`timescale 1ns / 1ps
`default_nettype none

module pkae_cross #(
   parameter int AW   = 20,
   parameter int BW   = 23,
   parameter int FRAC = 12
) (
   input  wire                           clock,
   input  pkae_pkg::cross_en_type        en,
   input  wire logic signed [AW-1:0]     a_vec [3],
   input  wire logic signed [BW-1:0]     b_vec [3],
   output logic signed [AW+BW-FRAC:0]    o_vec [3]
);

   localparam int PRW = AW + BW;
   localparam int DW  = AW + BW + 1;
   localparam int OW  = DW - FRAC;
   localparam logic signed [DW-1:0] HALF = DW'(1) <<< (FRAC - 1);

   logic signed [PRW-1:0] prod_ff [6];
   logic signed [PRW-1:0] prod_in [6];
   logic signed [OW-1:0]  res_ff  [3];
   logic signed [OW-1:0]  res_in  [3];
   logic signed [DW-1:0]  diff    [3];

   // six partial products, two per output component
   always_comb begin
      prod_in[0] = PRW'(a_vec[1]) * PRW'(b_vec[2]);
      prod_in[1] = PRW'(a_vec[2]) * PRW'(b_vec[1]);
      prod_in[2] = PRW'(a_vec[2]) * PRW'(b_vec[0]);
      prod_in[3] = PRW'(a_vec[0]) * PRW'(b_vec[2]);
      prod_in[4] = PRW'(a_vec[0]) * PRW'(b_vec[1]);
      prod_in[5] = PRW'(a_vec[1]) * PRW'(b_vec[0]);
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // difference, add half lsb, floor shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]   = DW'(prod_ff[2*i]) - DW'(prod_ff[2*i+1]) + HALF;
         res_in[i] = OW'(diff[i] >>> FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (en.diff) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign o_vec = res_ff;

endmodule

`default_nettype wire

// File: src/point_kinematics_and_error_unit.sv
// top level of the point kinematics and error unit
// depends on pkae_pkg and pkae_cross
`timescale 1ns / 1ps
`default_nettype none

// usage
// - csr channel writes the body point (local x/y/z) and the world target
//   (goal x/y/z); csr_ready is always high, unknown indexes are dropped.
//   write registers only while the pipeline is empty.
// - req channel takes one pose and motion word (rotation rows, origin,
//   linear/angular velocity and acceleration) per accepted handshake.
// - rsp channel returns one word per request: position, velocity,
//   acceleration and target error, each component saturated.
// - the seven register stages are: rotate products, rotate sum, two cross
//   product stages, two more for the second cross product, saturate.
// - throughput is one word per cycle while rsp_ready is high; every stage
//   has one multiplier layer or one add and compare.
// - when rsp_ready is low the last stage holds its word; earlier stages
//   keep filling bubbles, and req_ready falls once all seven are full.
// - reset clears all stage valid bits and the six config registers to 0.

module point_kinematics_and_error_unit #(
   parameter int COMPONENT_BITS = pkae_pkg::COMPONENT_BITS
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  pkae_pkg::req_word_type                  req_word,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output pkae_pkg::rsp_word_type                  rsp_word,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire [pkae_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire [COMPONENT_BITS-1:0]                csr_wdata
);

   localparam int B        = COMPONENT_BITS;
   localparam int FB       = pkae_pkg::FIELD_BITS;
   localparam int PW       = 3 * B;
   localparam int ROT_FRAC = B - 2;
   localparam int VEC_FRAC = B - 8;
   localparam int PRW      = 2 * B;
   localparam int SUMW     = 2 * B + 2;
   localparam int RW       = B + 3;
   localparam int CW       = B + RW + 1 - VEC_FRAC;
   localparam int WW       = B + CW + 1 - VEC_FRAC;
   localparam int SW       = WW + 2;
   localparam int NSTAGE   = 7;
   localparam logic signed [SUMW-1:0] ROT_HALF = SUMW'(1) <<< (ROT_FRAC - 1);

   // extract one signed component from a packed field
   function automatic logic signed [B-1:0] comp(input logic [FB-1:0] f, input int i);
      logic [PW-1:0] e;
      e = PW'(f);
      return e[i*B +: B];
   endfunction

   // clamp a wide signed value to the component range
   function automatic logic [B-1:0] sat(input logic signed [SW-1:0] x);
      logic all_zero;
      logic all_one;
      all_zero = (x[SW-1:B-1] == '0);
      all_one  = (x[SW-1:B-1] == '1);
      if (all_zero || all_one) begin
         return x[B-1:0];
      end else if (x[SW-1]) begin
         return {1'b1, {(B-1){1'b0}}};
      end else begin
         return {1'b0, {(B-1){1'b1}}};
      end
   endfunction

   // ---------------------------------------------------------------
   // config registers
   // ---------------------------------------------------------------
   logic signed [B-1:0] loc_ff  [3];
   logic signed [B-1:0] goal_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            loc_ff[i]  <= '0;
            goal_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pkae_pkg::REG_LOCAL_X: loc_ff[0]  <= csr_wdata;
            pkae_pkg::REG_LOCAL_Y: loc_ff[1]  <= csr_wdata;
            pkae_pkg::REG_LOCAL_Z: loc_ff[2]  <= csr_wdata;
            pkae_pkg::REG_GOAL_X:  goal_ff[0] <= csr_wdata;
            pkae_pkg::REG_GOAL_Y:  goal_ff[1] <= csr_wdata;
            pkae_pkg::REG_GOAL_Z:  goal_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage valid bits and per-stage advance
   // ---------------------------------------------------------------
   logic [NSTAGE:1] vld_ff;
   logic [NSTAGE:1] vld_in;
   logic [NSTAGE:1] adv;

   always_comb begin
      adv[NSTAGE] = !vld_ff[NSTAGE] || rsp_ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[1] = adv[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[1];
   assign rsp_valid = vld_ff[NSTAGE];

   // ---------------------------------------------------------------
   // stage 1: rotation entry times body point products
   // ---------------------------------------------------------------
   logic signed [B-1:0]   rot_c [3][3];
   logic signed [PRW-1:0] s1_prod_in [3][3];
   logic signed [PRW-1:0] s1_prod_ff [3][3];
   logic signed [B-1:0]   s1_t_ff  [3];
   logic signed [B-1:0]   s1_v_ff  [3];
   logic signed [B-1:0]   s1_w_ff  [3];
   logic signed [B-1:0]   s1_a_ff  [3];
   logic signed [B-1:0]   s1_al_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rot_c[0][j] = comp(req_word.rot_row0, j);
         rot_c[1][j] = comp(req_word.rot_row1, j);
         rot_c[2][j] = comp(req_word.rot_row2, j);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_prod_in[i][j] = PRW'(rot_c[i][j]) * PRW'(loc_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s1_prod_ff[i][j] <= s1_prod_in[i][j];
            end
            s1_t_ff[i]  <= comp(req_word.joint_origin, i);
            s1_v_ff[i]  <= comp(req_word.lin_vel, i);
            s1_w_ff[i]  <= comp(req_word.ang_vel, i);
            s1_a_ff[i]  <= comp(req_word.lin_acc, i);
            s1_al_ff[i] <= comp(req_word.ang_acc, i);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 2: r = round(R * p)
   // ---------------------------------------------------------------
   logic signed [SUMW-1:0] r_sum [3];
   logic signed [RW-1:0]   s2_r_in [3];
   logic signed [RW-1:0]   s2_r_ff [3];
   logic signed [B-1:0]    s2_t_ff  [3];
   logic signed [B-1:0]    s2_v_ff  [3];
   logic signed [B-1:0]    s2_w_ff  [3];
   logic signed [B-1:0]    s2_a_ff  [3];
   logic signed [B-1:0]    s2_al_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_sum[i] = SUMW'(s1_prod_ff[i][0]) + SUMW'(s1_prod_ff[i][1])
                  + SUMW'(s1_prod_ff[i][2]) + ROT_HALF;
         s2_r_in[i] = RW'(r_sum[i] >>> ROT_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int i = 0; i < 3; i++) begin
            s2_r_ff[i]  <= s2_r_in[i];
            s2_t_ff[i]  <= s1_t_ff[i];
            s2_v_ff[i]  <= s1_v_ff[i];
            s2_w_ff[i]  <= s1_w_ff[i];
            s2_a_ff[i]  <= s1_a_ff[i];
            s2_al_ff[i] <= s1_al_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // stages 3-4: w x r and alpha x r, position t + r
   // ---------------------------------------------------------------
   pkae_pkg::cross_en_type en_first;
   pkae_pkg::cross_en_type en_second;
   logic signed [CW-1:0] wr_c  [3];
   logic signed [CW-1:0] alr_c [3];

   assign en_first.prod  = adv[3];
   assign en_first.diff  = adv[4];
   assign en_second.prod = adv[5];
   assign en_second.diff = adv[6];

   pkae_cross #(
      .AW   (B),
      .BW   (RW),
      .FRAC (VEC_FRAC)
   ) u_cross_wr (
      .clock (clock),
      .en    (en_first),
      .a_vec (s2_w_ff),
      .b_vec (s2_r_ff),
      .o_vec (wr_c)
   );

   pkae_cross #(
      .AW   (B),
      .BW   (RW),
      .FRAC (VEC_FRAC)
   ) u_cross_alr (
      .clock (clock),
      .en    (en_first),
      .a_vec (s2_al_ff),
      .b_vec (s2_r_ff),
      .o_vec (alr_c)
   );

   logic signed [RW:0]  s3_pos_ff [3];
   logic signed [B-1:0] s3_v_ff   [3];
   logic signed [B-1:0] s3_w_ff   [3];
   logic signed [B-1:0] s3_a_ff   [3];
   logic signed [RW:0]  s4_pos_ff [3];
   logic signed [B-1:0] s4_v_ff   [3];
   logic signed [B-1:0] s4_w_ff   [3];
   logic signed [B-1:0] s4_a_ff   [3];

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int i = 0; i < 3; i++) begin
            s3_pos_ff[i] <= (RW+1)'(s2_t_ff[i]) + (RW+1)'(s2_r_ff[i]);
            s3_v_ff[i]   <= s2_v_ff[i];
            s3_w_ff[i]   <= s2_w_ff[i];
            s3_a_ff[i]   <= s2_a_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int i = 0; i < 3; i++) begin
            s4_pos_ff[i] <= s3_pos_ff[i];
            s4_v_ff[i]   <= s3_v_ff[i];
            s4_w_ff[i]   <= s3_w_ff[i];
            s4_a_ff[i]   <= s3_a_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // stages 5-6: w x (w x r), velocity and partial acceleration sums
   // ---------------------------------------------------------------
   logic signed [WW-1:0] wwr_c [3];

   pkae_cross #(
      .AW   (B),
      .BW   (CW),
      .FRAC (VEC_FRAC)
   ) u_cross_wwr (
      .clock (clock),
      .en    (en_second),
      .a_vec (s4_w_ff),
      .b_vec (wr_c),
      .o_vec (wwr_c)
   );

   logic signed [RW:0] s5_pos_ff [3];
   logic signed [CW:0] s5_vel_ff [3];
   logic signed [CW:0] s5_aa_ff  [3];
   logic signed [RW:0] s6_pos_ff [3];
   logic signed [CW:0] s6_vel_ff [3];
   logic signed [CW:0] s6_aa_ff  [3];

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int i = 0; i < 3; i++) begin
            s5_pos_ff[i] <= s4_pos_ff[i];
            s5_vel_ff[i] <= (CW+1)'(s4_v_ff[i]) + (CW+1)'(wr_c[i]);
            s5_aa_ff[i]  <= (CW+1)'(s4_a_ff[i]) + (CW+1)'(alr_c[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int i = 0; i < 3; i++) begin
            s6_pos_ff[i] <= s5_pos_ff[i];
            s6_vel_ff[i] <= s5_vel_ff[i];
            s6_aa_ff[i]  <= s5_aa_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 7: final sums, saturation and packing
   // ---------------------------------------------------------------
   logic [PW-1:0]         pos_pk;
   logic [PW-1:0]         vel_pk;
   logic [PW-1:0]         acc_pk;
   logic [PW-1:0]         err_pk;
   logic signed [SW-1:0]  acc_sum [3];
   logic signed [SW-1:0]  err_sum [3];
   pkae_pkg::rsp_word_type out_in;
   pkae_pkg::rsp_word_type out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_sum[i] = SW'(s6_aa_ff[i]) + SW'(wwr_c[i]);
         err_sum[i] = SW'(goal_ff[i]) - SW'(s6_pos_ff[i]);
         pos_pk[i*B +: B] = sat(SW'(s6_pos_ff[i]));
         vel_pk[i*B +: B] = sat(SW'(s6_vel_ff[i]));
         acc_pk[i*B +: B] = sat(acc_sum[i]);
         err_pk[i*B +: B] = sat(err_sum[i]);
      end
      out_in.point_pos = FB'(pos_pk);
      out_in.point_vel = FB'(vel_pk);
      out_in.point_acc = FB'(acc_pk);
      out_in.pos_error = FB'(err_pk);
   end

   always_ff @(posedge clock) begin
      if (adv[NSTAGE]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_word = out_ff;

endmodule

`default_nettype wire
